FILE: rtl/smbf_pkg.sv
`default_nettype none

package smbf_pkg;

    localparam int unsigned CostW = 42;
    localparam int unsigned ResCostW = 32;
    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CfgIndexW-1:0] CFG_REQ_WIDTH  = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_REQ_HEIGHT = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_REQ_FPS    = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_ONLY_PAD   = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_ONLY_MODE  = 3'd4;

    localparam logic [15:0] RST_REQ_WIDTH  = 16'd1920;
    localparam logic [15:0] RST_REQ_HEIGHT = 16'd1080;
    localparam logic [9:0]  RST_REQ_FPS    = 10'd30;

    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  mode_no;
        logic [8:0]  pad_mode_count;
        logic [15:0] mode_width;
        logic [15:0] mode_height;
        logic [9:0]  mode_min_fps;
        logic [9:0]  mode_max_fps;
        logic        last;
    } smbf_desc_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  best_sensor_pad;
        logic [7:0]  best_mode_no;
        logic [8:0]  best_mode_count;
        logic [15:0] best_width;
        logic [15:0] best_height;
        logic [9:0]  best_min_fps;
        logic [9:0]  best_max_fps;
        logic [1:0]  best_grade;
    } smbf_result_t;

    typedef struct packed {
        logic [15:0]       req_width;
        logic [15:0]       req_height;
        logic [9:0]        req_fps;
        logic signed [2:0] only_pad;
        logic signed [8:0] only_mode;
    } smbf_cfg_t;

    typedef struct packed {
        logic             take;
        logic [1:0]       cls;
        logic [CostW-1:0] cost;
        smbf_desc_t       desc;
    } smbf_score_t;

    typedef struct packed {
        logic             have;
        logic [1:0]       cls;
        logic [CostW-1:0] cost;
        logic [1:0]       pad;
        logic [7:0]       index;
        logic [8:0]       count;
        logic [15:0]      width;
        logic [15:0]      height;
        logic [9:0]       min_fps;
        logic [9:0]       max_fps;
    } smbf_run_t;

    typedef struct packed {
        logic fire;
    } smbf_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/sensor_mode_best_fit_selector_core.sv
// Channel   Signals                          Direction  Word
// desc      desc_valid desc_ready desc       in         smbf_desc_t
// result    result_valid result_ready result out        smbf_result_t
// cfg       cfg_valid cfg_ready cfg_index    in         16-bit data, index 0..4
//           cfg_data
//
// One descriptor a cycle while the score stage is not held; the result is registered.
// Stages: input register, score register (filters, class, 42-bit cost), running best.
// Reset clears the targets to 1920x1080 at 30 fps, no forced pad or mode, no best held.
// A stalled result holds the score stage only when that stage holds a last descriptor.
`default_nettype none

module sensor_mode_best_fit_selector_core
    import smbf_pkg::*;
#(
    parameter int unsigned NUM_PADS  = 4,
    parameter int unsigned MAX_MODES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 desc_valid,
    output logic                 desc_ready,
    input  smbf_desc_t           desc,
    output logic                 result_valid,
    input  logic                 result_ready,
    output smbf_result_t         result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    smbf_cfg_t   cfg_reg;
    smbf_cfg_t   cfg_next;
    logic        a_valid_reg;
    logic        a_valid_next;
    smbf_desc_t  a_reg;
    logic        b_valid_reg;
    logic        b_valid_next;
    smbf_score_t b_reg;
    smbf_score_t score;
    smbf_ctrl_t  ctrl;
    logic        out_free;
    logic        b_load_ok;
    logic        a_advance;
    logic        desc_accept;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REQ_WIDTH:  cfg_next.req_width  = cfg_data;
                CFG_REQ_HEIGHT: cfg_next.req_height = cfg_data;
                CFG_REQ_FPS:    cfg_next.req_fps    = cfg_data[9:0];
                CFG_ONLY_PAD:   cfg_next.only_pad   = cfg_data[2:0];
                CFG_ONLY_MODE:  cfg_next.only_mode  = cfg_data[8:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    smbf_scorer #(
        .NUM_PADS  (NUM_PADS),
        .MAX_MODES (MAX_MODES)
    ) u_scorer (
        .cfg   (cfg_reg),
        .desc  (a_reg),
        .score (score)
    );

    always_comb
    begin
        out_free     = !result_valid || result_ready;
        ctrl.fire    = b_valid_reg && (!b_reg.desc.last || out_free);
        b_load_ok    = !b_valid_reg || ctrl.fire;
        a_advance    = a_valid_reg && b_load_ok;
        desc_ready   = !a_valid_reg || b_load_ok;
        desc_accept  = desc_valid && desc_ready;
        a_valid_next = desc_accept || (a_valid_reg && !a_advance);
        b_valid_next = a_advance || (b_valid_reg && !ctrl.fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.req_width  <= RST_REQ_WIDTH;
            cfg_reg.req_height <= RST_REQ_HEIGHT;
            cfg_reg.req_fps    <= RST_REQ_FPS;
            cfg_reg.only_pad   <= '1;
            cfg_reg.only_mode  <= '1;
            a_valid_reg        <= 1'b0;
            b_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_accept)
        begin
            a_reg <= desc;
        end
        if (a_advance)
        begin
            b_reg <= score;
        end
    end

    smbf_selector u_selector (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .score        (b_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        desc_valid && desc_ready |=> a_valid_reg)
        else $error("accepted descriptor lost at input stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_reg.desc.last && result_valid && !result_ready |=> b_valid_reg)
        else $error("last descriptor dropped while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.best_grade == 2'd0
            && result.best_width == 16'd0 && result.best_height == 16'd0
            && result.best_mode_count == 9'd0)
        else $error("empty result carries mode fields");

endmodule

`default_nettype wire

FILE: rtl/smbf_scorer.sv
`default_nettype none

module smbf_scorer
    import smbf_pkg::*;
#(
    parameter int unsigned NUM_PADS  = 4,
    parameter int unsigned MAX_MODES = 256
) (
    input  smbf_cfg_t   cfg,
    input  smbf_desc_t  desc,
    output smbf_score_t score
);

    localparam logic [2:0] PadLimit  = 3'(NUM_PADS);
    localparam logic [8:0] ModeLimit = 9'(MAX_MODES);

    logic                pad_ok;
    logic                idx_ok;
    logic                force_ok;
    logic                fit;
    logic                rate_ok;
    logic [15:0]         dw;
    logic [15:0]         dh;
    logic [31:0]         dw_sq;
    logic [31:0]         dh_sq;
    logic [ResCostW-1:0] res_sum;
    logic [9:0]          excess;

    always_comb
    begin
        pad_ok = {1'b0, desc.pad} < PadLimit;
        idx_ok = ({1'b0, desc.mode_no} < desc.pad_mode_count)
              && ({1'b0, desc.mode_no} < ModeLimit);
        force_ok = (cfg.only_pad[2] || ({1'b0, desc.pad} == cfg.only_pad))
                && (cfg.only_mode[8] || ({1'b0, desc.mode_no} == cfg.only_mode));

        fit = (desc.mode_width >= cfg.req_width)
           && (desc.mode_height >= cfg.req_height);
        rate_ok = (cfg.req_fps == 10'd0)
               || (((desc.mode_max_fps == 10'd0) || (cfg.req_fps <= desc.mode_max_fps))
                && ((desc.mode_min_fps == 10'd0) || (cfg.req_fps >= desc.mode_min_fps)));

        dw = (desc.mode_width > cfg.req_width) ? desc.mode_width - cfg.req_width
                                               : cfg.req_width - desc.mode_width;
        dh = (desc.mode_height > cfg.req_height) ? desc.mode_height - cfg.req_height
                                                 : cfg.req_height - desc.mode_height;
        dw_sq = 32'(dw) * 32'(dw);
        dh_sq = 32'(dh) * 32'(dh);
        res_sum = dw_sq + dh_sq;

        excess = ((cfg.req_fps != 10'd0) && (desc.mode_max_fps > cfg.req_fps))
               ? desc.mode_max_fps - cfg.req_fps : 10'd0;

        score.take = pad_ok && idx_ok && force_ok;
        score.cls  = {rate_ok, fit};
        score.cost = {excess, res_sum};
        score.desc = desc;
    end

endmodule

`default_nettype wire

FILE: rtl/smbf_selector.sv
`default_nettype none

module smbf_selector
    import smbf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  smbf_ctrl_t   ctrl,
    input  smbf_score_t  score,
    output logic         result_valid,
    input  logic         result_ready,
    output smbf_result_t result
);

    smbf_run_t    run_reg;
    smbf_run_t    run_next;
    smbf_run_t    cand;
    smbf_run_t    merged;
    logic         better;
    logic         result_valid_reg;
    logic         result_valid_next;
    smbf_result_t result_reg;
    smbf_result_t result_next;

    always_comb
    begin
        cand.have    = 1'b1;
        cand.cls     = score.cls;
        cand.cost    = score.cost;
        cand.pad     = score.desc.pad;
        cand.index   = score.desc.mode_no;
        cand.count   = score.desc.pad_mode_count;
        cand.width   = score.desc.mode_width;
        cand.height  = score.desc.mode_height;
        cand.min_fps = score.desc.mode_min_fps;
        cand.max_fps = score.desc.mode_max_fps;

        better = score.take && (!run_reg.have || (score.cls > run_reg.cls)
              || ((score.cls == run_reg.cls) && (score.cost < run_reg.cost)));
        merged = better ? cand : run_reg;

        run_next = run_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next = result_reg;
        if (ctrl.fire)
        begin
            if (score.desc.last)
            begin
                run_next = '0;
                result_valid_next = 1'b1;
                result_next.found           = merged.have;
                result_next.best_sensor_pad = merged.pad;
                result_next.best_mode_no    = merged.index;
                result_next.best_mode_count = merged.count;
                result_next.best_width      = merged.width;
                result_next.best_height     = merged.height;
                result_next.best_min_fps    = merged.min_fps;
                result_next.best_max_fps    = merged.max_fps;
                result_next.best_grade      = merged.cls;
            end
            else
            begin
                run_next = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg          <= run_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
